### rtl/core/argument_tokenizer_defines.svh
// Assertion macros used by the argument tokenizer checker.
// Include with the bare file name; no other dependencies.
`ifndef ARGUMENT_TOKENIZER_DEFINES_SVH
`define ARGUMENT_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARGT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARGT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/argt_pkg.sv
// Shared constants and types of the argument tokenizer.
// No dependencies; used by every module of the block.
package argt_pkg;

   localparam int COUNT_BITS = 8;
   localparam int LIM_W      = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'((1 << COUNT_BITS) - 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_MASK = 8'h1F;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FIELDS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FANCY_MODE = 1'b1;

   localparam int REQ_W = 8;
   localparam int RSP_W = 32;

   // Bit positions of the result word.
   localparam int RSP_BYTE_VALID  = 0;
   localparam int RSP_OUT_BYTE    = 1;
   localparam int RSP_FIELD_INDEX = 9;
   localparam int RSP_FIELD_START = 17;
   localparam int RSP_FIELD_END   = 18;
   localparam int RSP_FIELD_COUNT = 19;
   localparam int RSP_TOO_MANY    = 27;
   localparam int RSP_USED        = 28;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [7:0] field_index;
      logic       field_start;
      logic       field_end;
      logic       line_done;
      logic [7:0] field_count;
      logic       too_many;
   } rsp_item_type;

endpackage

### rtl/core/argt_core.sv
// Per-byte tokenizer state and next-result logic of the argument tokenizer.
// Depends on argt_pkg.
module argt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic [7:0]            max_fields,
   input  logic                  fancy_mode,
   output argt_pkg::rsp_item_type result
);
   import argt_pkg::*;

   typedef enum logic [1:0] {PH_BETWEEN, PH_FIELD, PH_CARET} phase_type;
   typedef enum logic [1:0] {Q_NONE, Q_DOUBLE, Q_SINGLE} quote_type;

   phase_type              phase_ff, phase_in;
   quote_type              quote_ff, quote_in, cur_quote, kind;
   logic [COUNT_BITS-1:0]  count_ff, count_in, cur_count;
   logic                   stopped_ff, stopped_in;

   logic                   is_term, is_blank, is_nul, is_quote, open_field;
   logic [LIM_W-1:0]       count_w, idx_w, cur_count_w, cur_idx_w, mf_w, limit_w;
   logic [7:0]             esc_byte;
   rsp_item_type           res;

   assign is_nul     = (in_byte == CH_NUL);
   assign is_term    = is_nul || (in_byte == CH_NL);
   assign is_blank   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
   assign is_quote   = (in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE);
   assign kind       = (in_byte == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;

   assign mf_w       = LIM_W'(max_fields);
   assign limit_w    = (mf_w < COUNT_MAX) ? mf_w : COUNT_MAX;
   assign count_w    = LIM_W'(count_ff);
   assign idx_w      = count_w - 1'b1;

   // A byte that is not a blank opens a new field when none is open and the field limit is not reached.
   assign open_field  = (phase_ff == PH_BETWEEN);
   assign cur_count   = open_field ? count_ff + 1'b1 : count_ff;
   assign cur_quote   = open_field ? Q_NONE : quote_ff;
   assign cur_count_w = LIM_W'(cur_count);
   assign cur_idx_w   = cur_count_w - 1'b1;

   always_comb begin
      case (in_byte)
         CH_CARET: esc_byte = CH_CARET;
         CH_QMARK: esc_byte = CH_DEL;
         default:  esc_byte = in_byte & CTRL_MASK;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      quote_in   = quote_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      res        = '0;
      if (phase_ff == PH_CARET && fancy_mode && !is_nul && !stopped_ff) begin
         res.byte_valid  = 1'b1;
         res.out_byte    = esc_byte;
         res.field_index = idx_w[7:0];
         res.field_count = count_w[7:0];
         phase_in        = PH_FIELD;
      end else if (is_term) begin
         if (phase_ff != PH_BETWEEN && !stopped_ff) begin
            res.field_end   = 1'b1;
            res.field_index = idx_w[7:0];
         end
         res.line_done   = 1'b1;
         res.field_count = count_w[7:0];
         res.too_many    = (count_w >= limit_w);
         phase_in        = PH_BETWEEN;
         quote_in        = Q_NONE;
         count_in        = '0;
         stopped_in      = 1'b0;
      end else if (stopped_ff || (open_field && is_blank)) begin
         res.field_count = count_w[7:0];
      end else if (open_field && count_w >= limit_w) begin
         stopped_in      = 1'b1;
         res.field_count = count_w[7:0];
      end else begin
         res.field_start = open_field;
         res.field_index = cur_idx_w[7:0];
         res.field_count = cur_count_w[7:0];
         count_in        = cur_count;
         quote_in        = cur_quote;
         phase_in        = PH_FIELD;
         if (is_blank && (!fancy_mode || cur_quote == Q_NONE)) begin
            res.field_end = 1'b1;
            phase_in      = PH_BETWEEN;
         end else if (fancy_mode && in_byte == CH_CARET) begin
            phase_in = PH_CARET;
         end else if (fancy_mode && is_quote) begin
            if (cur_quote == kind) begin
               quote_in = Q_NONE;
            end else if (cur_quote != Q_NONE) begin
               res.byte_valid = 1'b1;
               res.out_byte   = in_byte;
            end else begin
               quote_in = kind;
            end
         end else begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         quote_ff   <= Q_NONE;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         quote_ff   <= quote_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

   assign result = res;

endmodule

### rtl/core/argument_tokenizer.sv
// Each accepted word's result word is registered in the output register.
// Throughput: one word per cycle unless the output stalls; the state update
// of argt_core and a single output register sit between the two channels, so
// input is taken while a result waits whenever the waiting result is taken in
// the same cycle. Reset (synchronous, active high) clears the tokenizer state
// and the output valid, and sets max_fields to 20 and plain mode.
module argument_tokenizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [argt_pkg::REQ_W-1:0]     req_tdata,  // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] byte_valid, [8:1] out_byte, [16:9] field_index, [17] field_start,
   // [18] field_end, [26:19] field_count, [27] too_many, [31:28] zero
   output logic [argt_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                           rsp_tlast,  // line_done
   input  logic                           csr_we,
   input  logic [argt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [argt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import argt_pkg::*;

   logic                 accept;
   logic [7:0]           max_fields_ff;
   logic                 fancy_mode_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff;
   rsp_item_type         result;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   argt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata[7:0]),
      .max_fields (max_fields_ff),
      .fancy_mode (fancy_mode_ff),
      .result     (result)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_BYTE_VALID]                = result.byte_valid;
      rsp_data_in[RSP_OUT_BYTE +: 8]             = result.out_byte;
      rsp_data_in[RSP_FIELD_INDEX +: 8]          = result.field_index;
      rsp_data_in[RSP_FIELD_START]               = result.field_start;
      rsp_data_in[RSP_FIELD_END]                 = result.field_end;
      rsp_data_in[RSP_FIELD_COUNT +: 8]          = result.field_count;
      rsp_data_in[RSP_TOO_MANY]                  = result.too_many;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         max_fields_ff <= 8'd20;
         fancy_mode_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MAX_FIELDS: max_fields_ff <= csr_wdata[7:0];
               CSR_FANCY_MODE: fancy_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= result.line_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/argt_checker.sv
// Port-level checks of the argument tokenizer, bound to the top level.
// Depends on argt_pkg and argument_tokenizer_defines.svh.
`include "argument_tokenizer_defines.svh"

module argt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [argt_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);
   import argt_pkg::*;

   // A held word must not change under a stall.
   `ARGT_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed while stalled")

   // Every accepted byte yields a result word in the next cycle.
   `ARGT_ASSERT_NEXT(a_one_cycle, clock, reset, req_tvalid && req_tready, rsp_tvalid, "accepted byte gave no result")

   // A field closed by a blank carries no byte of its own.
   `ARGT_ASSERT_SAME(a_end_no_byte, clock, reset, rsp_tvalid && rsp_tdata[RSP_FIELD_END] && !rsp_tlast, !rsp_tdata[RSP_BYTE_VALID], "blank closing a field emitted a byte")

   // Overflow is only reported with the word that ends the line.
   `ARGT_ASSERT_SAME(a_overflow_at_end, clock, reset, rsp_tvalid && !rsp_tlast, !rsp_tdata[RSP_TOO_MANY], "overflow flagged before line end")

endmodule

bind argument_tokenizer argt_checker u_argt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### verif/tb_top.sv
// Self-checking testbench for the argument tokenizer: random stalls on both streams,
// a byte-level predictor of the tokenizer, and register changes between phases.
// Depends on argt_pkg and the argument_tokenizer RTL only.
`timescale 1ns / 100ps

module tb_top;
   import argt_pkg::*;

   typedef enum logic [1:0] {TOK_BETWEEN, TOK_IN_FIELD, TOK_AFTER_CARET} tok_phase_type;
   typedef enum logic [1:0] {QUOTE_NONE, QUOTE_DOUBLE, QUOTE_SINGLE} quote_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;       // [7:0] in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] byte_valid, [8:1] out_byte, [16:9] field_index, [17] field_start,
   // [18] field_end, [26:19] field_count, [27] too_many
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;            // line_done
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   argument_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state and its copy of the registers.
   tok_phase_type tok_phase = TOK_BETWEEN;
   quote_type     quote_state = QUOTE_NONE;
   int           field_cnt = 0;
   bit           fields_stopped = 1'b0;
   logic [7:0]   cfg_max_fields = 8'd20;
   bit           cfg_fancy = 1'b0;

   logic [7:0]   line_bytes_q[$];
   rsp_item_type token_results_q[$];

   bit           no_gap_mode = 1'b0;
   int           send_gap = 0;
   int           recv_stall = 0;
   int unsigned  stall_draw;
   rsp_item_type want_item, got_item;

   int           mismatches = 0;
   int           bytes_sent = 0;
   int           words_checked = 0;
   int           lines_ended = 0;
   int           reg_writes = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic rsp_item_type tokenize_byte(input logic [7:0] b);
      rsp_item_type r;
      bit is_term;
      bit is_blank;
      int limit;
      r        = '0;
      is_term  = (b == CH_NUL) || (b == CH_NL);
      is_blank = (b == CH_SPACE) || (b == CH_TAB);
      limit    = (int'(cfg_max_fields) < int'(COUNT_MAX)) ? int'(cfg_max_fields)
                                                          : int'(COUNT_MAX);

      // A pending caret escapes the next byte, except a NUL which ends the line.
      if (tok_phase == TOK_AFTER_CARET && cfg_fancy && b != CH_NUL && !fields_stopped) begin
         r.byte_valid  = 1'b1;
         if (b == CH_CARET)
            r.out_byte = CH_CARET;
         else if (b == CH_QMARK)
            r.out_byte = CH_DEL;
         else
            r.out_byte = b & CTRL_MASK;
         r.field_index = 8'(field_cnt - 1);
         r.field_count = 8'(field_cnt);
         tok_phase     = TOK_IN_FIELD;
         return r;
      end

      if (is_term) begin
         if (tok_phase != TOK_BETWEEN && !fields_stopped) begin
            r.field_end   = 1'b1;
            r.field_index = 8'(field_cnt - 1);
         end
         r.line_done    = 1'b1;
         r.field_count  = 8'(field_cnt);
         r.too_many     = (field_cnt >= limit);
         tok_phase      = TOK_BETWEEN;
         quote_state    = QUOTE_NONE;
         field_cnt      = 0;
         fields_stopped = 1'b0;
         return r;
      end

      if (fields_stopped) begin
         r.field_count = 8'(field_cnt);
         return r;
      end

      if (tok_phase == TOK_BETWEEN) begin
         if (is_blank) begin
            r.field_count = 8'(field_cnt);
            return r;
         end
         if (field_cnt >= limit) begin
            fields_stopped = 1'b1;
            r.field_count  = 8'(field_cnt);
            return r;
         end
         field_cnt     = (field_cnt + 1) & ((1 << COUNT_BITS) - 1);
         quote_state   = QUOTE_NONE;
         r.field_start = 1'b1;
      end
      // A caret left over from fancy mode is simply dropped here.
      tok_phase = TOK_IN_FIELD;

      r.field_index = 8'(field_cnt - 1);
      r.field_count = 8'(field_cnt);

      if (!cfg_fancy) begin
         if (is_blank) begin
            r.field_end = 1'b1;
            tok_phase   = TOK_BETWEEN;
         end else begin
            r.byte_valid = 1'b1;
            r.out_byte   = b;
         end
      end else if (quote_state == QUOTE_NONE && is_blank) begin
         r.field_end = 1'b1;
         tok_phase   = TOK_BETWEEN;
      end else if (b == CH_CARET) begin
         tok_phase = TOK_AFTER_CARET;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         quote_type kind;
         kind = (b == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
         if (quote_state == kind) begin
            quote_state = QUOTE_NONE;
         end else if (quote_state != QUOTE_NONE) begin
            r.byte_valid = 1'b1;
            r.out_byte   = b;
         end else begin
            quote_state = kind;
         end
      end else begin
         r.byte_valid = 1'b1;
         r.out_byte   = b;
      end
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // Driver: one word from the byte queue at a time, with a random gap after each unless no-gap mode is set.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            token_results_q.push_back(tokenize_byte(req_tdata));
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (line_bytes_q.size() > 0) begin
               req_tdata  <= line_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               send_gap   <= no_gap_mode ? 0 : $urandom_range(0, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word and then holds ready low for a random stall unless no-gap mode is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got_item.byte_valid  = rsp_tdata[RSP_BYTE_VALID];
         got_item.out_byte    = rsp_tdata[RSP_OUT_BYTE +: 8];
         got_item.field_index = rsp_tdata[RSP_FIELD_INDEX +: 8];
         got_item.field_start = rsp_tdata[RSP_FIELD_START];
         got_item.field_end   = rsp_tdata[RSP_FIELD_END];
         got_item.line_done   = rsp_tlast;
         got_item.field_count = rsp_tdata[RSP_FIELD_COUNT +: 8];
         got_item.too_many    = rsp_tdata[RSP_TOO_MANY];
         if (token_results_q.size() == 0) begin
            $display("%0t: result word 0x%0h arrived with none expected", $time, rsp_tdata);
            mismatches++;
         end else begin
            want_item = token_results_q.pop_front();
            check_field("byte_valid", 8'(want_item.byte_valid), 8'(got_item.byte_valid));
            check_field("out_byte", want_item.out_byte, got_item.out_byte);
            check_field("field_index", want_item.field_index, got_item.field_index);
            check_field("field_start", 8'(want_item.field_start), 8'(got_item.field_start));
            check_field("field_end", 8'(want_item.field_end), 8'(got_item.field_end));
            check_field("line_done", 8'(want_item.line_done), 8'(got_item.line_done));
            check_field("field_count", want_item.field_count, got_item.field_count);
            check_field("too_many", 8'(want_item.too_many), 8'(got_item.too_many));
         end
         words_checked++;
         if (rsp_tlast)
            lines_ended++;
         stall_draw = no_gap_mode ? 0 : $urandom_range(0, 10);
         recv_stall <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= (recv_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Returns at a falling edge once every queued byte has been taken and checked.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (line_bytes_q.size() != 0 || req_tvalid || token_results_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (addr == CSR_MAX_FIELDS)
         cfg_max_fields = data;
      else
         cfg_fancy = data[0];
      reg_writes++;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'($urandom_range(8'h21, 8'h7E));
      if (r < 55) return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      if (r < 65) return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      if (r < 77) return CH_CARET;
      if (r < 80) return CH_QMARK;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_line(input int words, input bit terminated, output int pushed);
      int len;
      pushed = 0;
      for (int w = 0; w < words; w++) begin
         repeat ($urandom_range(0, 2)) begin
            line_bytes_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            pushed++;
         end
         len = $urandom_range(1, 6);
         repeat (len) begin
            line_bytes_q.push_back(pick_char());
            pushed++;
         end
      end
      if (terminated) begin
         line_bytes_q.push_back($urandom_range(0, 1) ? CH_NL : CH_NUL);
         pushed++;
      end
   endtask

   initial begin
      int random_bytes;
      int phase_bytes;
      int target;
      int n;
      logic [7:0] limit_pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Plain mode: extreme byte values, tab and blank separators, overflow at two fields.
      write_csr(CSR_MAX_FIELDS, 8'd2);
      write_csr(CSR_FANCY_MODE, 8'd0);
      line_bytes_q = {8'hFF, CH_TAB, 8'h78, CH_SPACE, 8'h80, CH_NL};
      wait_idle();

      // Fancy mode: all caret escapes, both quote kinds, caret before blank and newline,
      // a line ending inside quotes, and a caret dropped before NUL.
      write_csr(CSR_MAX_FIELDS, 8'd255);
      write_csr(CSR_FANCY_MODE, 8'd1);
      line_bytes_q = {CH_CARET, CH_CARET, CH_CARET, CH_QMARK, CH_CARET, 8'h41, CH_SPACE,
                      CH_DQUOTE, 8'h61, CH_SPACE, CH_SQUOTE, CH_DQUOTE, CH_CARET, CH_SPACE,
                      CH_CARET, CH_NL, CH_SQUOTE, 8'h62, CH_CARET, CH_NUL};
      wait_idle();

      // Switch to plain mode with an open quote and a pending caret.
      write_csr(CSR_MAX_FIELDS, 8'd1);
      line_bytes_q = {CH_DQUOTE, CH_CARET};
      wait_idle();
      write_csr(CSR_FANCY_MODE, 8'd0);
      line_bytes_q = {CH_SPACE, 8'h7A, CH_NUL};
      wait_idle();

      // One line that runs the field count up to the largest limit and past it.
      write_csr(CSR_MAX_FIELDS, 8'd255);
      no_gap_mode = 1'b1;
      repeat (256) begin
         line_bytes_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
         line_bytes_q.push_back(CH_SPACE);
      end
      line_bytes_q.push_back(CH_NL);
      random_bytes = 513;
      wait_idle();

      while (random_bytes < 1250) begin
         case ($urandom_range(0, 7))
            0:       limit_pick = 8'd0;
            1:       limit_pick = 8'd1;
            2:       limit_pick = 8'd2;
            3:       limit_pick = 8'd3;
            4:       limit_pick = 8'd255;
            default: limit_pick = 8'($urandom_range(4, 254));
         endcase
         write_csr(CSR_MAX_FIELDS, limit_pick);
         write_csr(CSR_FANCY_MODE, 8'($urandom_range(0, 1)));
         no_gap_mode = ($urandom_range(0, 3) == 0);
         target      = $urandom_range(20, 80);
         phase_bytes = 0;
         // Some phases stop mid-line so the next settings apply to a line in progress.
         while (phase_bytes < target) begin
            push_line($urandom_range(0, 6), $urandom_range(0, 5) != 0, n);
            phase_bytes += n;
         end
         random_bytes += phase_bytes;
         wait_idle();
      end

      repeat (4) @(posedge clock);
      $display("Covered %0d input words and %0d checked result words over %0d lines,",
               bytes_sent, words_checked, lines_ended);
      $display("with %0d register writes across plain and fancy modes.", reg_writes);
      if (mismatches == 0 && token_results_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
